// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the substring search RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SFM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define SFM_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define SFM_ASSERT(lbl, clk, rstn, prop, msg)
`define SFM_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- hdl/sfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg
// Types, constants and helpers shared by the substring search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PATTERN_CAP     = 16;
	localparam int LEN_W           = 5;
	localparam int SEEN_W          = 9;
	localparam int CNT_W           = SEEN_W + 1;
	localparam int POS_W           = 8;
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 64;

	localparam logic [SEEN_W-1:0] SEEN_CAP = 9'd511;
	localparam logic [POS_W-1:0]  POS_CAP  = 8'd255;

	// Register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_LAST  = 2'd1;
	localparam logic [1:0] REG_LEN   = 2'd2;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [PATTERN_CAP-1:0][7:0] pattern;
		logic [LEN_W-1:0]            length;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic             armed;
		logic [POS_W-1:0] start;
	} ctl_t;

	function automatic byte_t pattern_byte(input logic [PATTERN_CAP-1:0][7:0] pat,
			input logic [3:0] idx);
		return pat[idx];
	endfunction

endpackage

// ----- hdl/sfm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_cfg
// APB register file: pattern bytes and pattern length.
// ----------------------------------------------------------------------------
module sfm_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfm_pkg::ADDR_W-1:0] paddr,
	input  logic [sfm_pkg::DATA_W-1:0] pwdata,
	output logic [sfm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output sfm_pkg::cfg_t              cfg
);
	import sfm_pkg::*;

	logic [DATA_W-1:0] first_q;
	logic [DATA_W-1:0] last_q;
	logic [LEN_W-1:0]  len_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
			len_q   <= '0;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_FIRST: first_q <= pwdata;
				REG_LAST:  last_q  <= pwdata;
				REG_LEN:   len_q   <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_FIRST: prdata = first_q;
			REG_LAST:  prdata = last_q;
			REG_LEN:   prdata = DATA_W'(len_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.pattern = {last_q, first_q};
	assign cfg.length  = len_q;

endmodule

// ----- hdl/sfm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_cell
// One window slot: holds a byte, passes it on, compares the incoming byte.
// ----------------------------------------------------------------------------
module sfm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           clear,
	input  logic           active,
	input  sfm_pkg::byte_t shift_in,
	input  sfm_pkg::byte_t pat_byte,
	output sfm_pkg::byte_t data_q,
	output logic           eq_s1
);
	import sfm_pkg::*;

	// Idle slots outside the pattern always agree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
			eq_s1  <= 1'b0;
		end else if (en) begin
			data_q <= clear ? byte_t'(0) : shift_in;
			eq_s1  <= !active || (shift_in == pat_byte);
		end
	end

endmodule

// ----- hdl/sfm_tally.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_tally
// Reduces cell compares, keeps the first match, holds the line result.
// ----------------------------------------------------------------------------
module sfm_tally #(
	parameter int PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sfm_pkg::ctl_t             ctl_s1,
	input  logic [PATTERN_MAX-1:0]    eq_s1,
	input  logic                      len_zero,
	input  logic                      out_ready,
	output logic                      adv,
	output logic                      out_valid,
	output logic                      found,
	output logic [sfm_pkg::POS_W-1:0] match_position
);
	import sfm_pkg::*;

	logic             match_seen_q;
	logic [POS_W-1:0] first_q;
	logic             hit;
	logic             load;

	assign hit  = ctl_s1.valid && ctl_s1.armed && (&eq_s1);
	// Only a line end can wait on a full result register
	assign adv  = !(ctl_s1.valid && ctl_s1.last) || !out_valid || out_ready;
	assign load = ctl_s1.valid && ctl_s1.last && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q <= 1'b0;
			first_q      <= '0;
		end else if (load) begin
			match_seen_q <= 1'b0;
			first_q      <= '0;
		end else if (hit && !match_seen_q) begin
			match_seen_q <= 1'b1;
			first_q      <= ctl_s1.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found <= len_zero || match_seen_q || hit;
			if (len_zero) begin
				match_position <= '0;
			end else if (match_seen_q) begin
				match_position <= first_q;
			end else if (hit) begin
				match_position <= ctl_s1.start;
			end else begin
				match_position <= '0;
			end
		end
	end

endmodule

// ----- hdl/substring_first_match.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// substring_first_match
// Streams one text line a byte at a time and reports the first occurrence
// of a configured pattern of up to 16 bytes when the line ends.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------
//  input     in_valid / in_ready   text_byte[7:0], line_end
//  output    out_valid / out_ready found, match_position[7:0]
//  config    APB, pready tied high paddr[4:0], pwdata/prdata[63:0]
//
//  One byte per cycle while in_ready is high. Each byte enters the window
//  cells in the cycle it is accepted; the cell compares are registered and
//  reduced in the next cycle, and a line end then loads the result register.
//  in_ready drops only while a line end waits in the compare stage and the
//  result register is still full and not being taken.
//  Reset clears the window, the line counters and the configuration registers at once;
//  no sweep is needed.
//
// Register map (8-byte stride):
//   0x00 pattern_first_eight, 0x08 pattern_last_eight, 0x10 pattern_length.
// ----------------------------------------------------------------------------
module substring_first_match #(
	parameter int PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// text stream
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 text_byte,
	input  logic                       line_end,
	// line result
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [sfm_pkg::POS_W-1:0]  match_position,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfm_pkg::ADDR_W-1:0] paddr,
	input  logic [sfm_pkg::DATA_W-1:0] pwdata,
	output logic [sfm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import sfm_pkg::*;

	// Patterns beyond 16 bytes cannot be configured; extra cells only shift
	localparam int LEN_CAP = (PATTERN_MAX < PATTERN_CAP) ? PATTERN_MAX : PATTERN_CAP;

	cfg_t              cfg;
	logic [LEN_W-1:0]  len_used;
	logic              accept;
	logic              adv;

	byte_t             window [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq_s1;

	logic [SEEN_W-1:0] bytes_seen_q;
	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  start_full;
	logic              armed;
	logic [POS_W-1:0]  start_sat;
	ctl_t              ctl_s1;

	sfm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the configured length to what the window can hold
	assign len_used = (cfg.length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : cfg.length;

	assign in_ready = adv;
	assign accept   = in_valid && in_ready;

	// Window chain: cell 0 holds the newest byte. Cell i lines up with
	// pattern byte len-1-i, so pattern byte 0 meets the oldest window byte.
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] k;
		byte_t      shift_in;

		assign k = 8'(len_used) - 8'(i) - 8'd1;

		if (i == 0) begin : g_head
			assign shift_in = text_byte;
		end else begin : g_body
			assign shift_in = window[i-1];
		end

		sfm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (accept),
			.clear    (line_end),
			.active   (8'(i) < 8'(len_used)),
			.shift_in (shift_in),
			.pat_byte (pattern_byte(cfg.pattern, k[3:0])),
			.data_q   (window[i]),
			.eq_s1    (eq_s1[i])
		);
	end

	// Line position: count is the number of bytes including this one
	assign count      = CNT_W'(bytes_seen_q) + CNT_W'(1);
	assign armed      = (len_used != '0) && (count >= CNT_W'(len_used));
	assign start_full = count - CNT_W'(len_used);
	assign start_sat  = (start_full > CNT_W'(POS_CAP)) ? POS_CAP : start_full[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				bytes_seen_q <= '0;
			end else if (bytes_seen_q != SEEN_CAP) begin
				bytes_seen_q <= bytes_seen_q + SEEN_W'(1);
			end
		end
	end

	// Compare stage control; advance whenever the tally can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.last  <= line_end;
			ctl_s1.armed <= armed;
			ctl_s1.start <= start_sat;
		end
	end

	sfm_tally #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_s1         (ctl_s1),
		.eq_s1          (eq_s1),
		.len_zero       (len_used == '0),
		.out_ready      (out_ready),
		.adv            (adv),
		.out_valid      (out_valid),
		.found          (found),
		.match_position (match_position)
	);

	`SFM_ASSERT_NEVER(a_pos_without_match, clk, arst_n, out_valid && !found && (match_position != '0), "position set on a miss")
	`SFM_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> (ctl_s1.valid && ctl_s1.last && out_valid), "input stalled without a waiting line end")
	`SFM_ASSERT(a_line_clear, clk, arst_n, (accept && line_end) |=> (bytes_seen_q == '0), "line counter not cleared at line end")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match testbench
// Streams text lines through the search block and checks each line result
// against a cycle-free prediction. Patterns and lengths are reloaded over
// APB between line batches. Stream sides throttle at random in phases 0 and 1.
// ----------------------------------------------------------------------------
module testbench;
	import sfm_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHORT_BUDGET = 170;
	localparam int LONG_LINE    = 540;
	localparam int MAX_REPORTS  = 10;
	// The block clamps the length register to the smaller of its window depth
	// and the hard cap of 16.
	localparam int LEN_CLAMP = (PATTERN_MAX_DEF < PATTERN_CAP) ? PATTERN_MAX_DEF : PATTERN_CAP;

	typedef struct {
		logic  found;
		byte_t position;
	} line_result_t;

	// Tracks the pattern registers and the per-line search state, and holds
	// the line results still owed by the block, oldest first.
	class search_scoreboard;
		byte_t        pattern[PATTERN_CAP];
		logic [4:0]   length_reg;
		byte_t        window[PATTERN_CAP];
		logic [8:0]   seen;
		bit           hit_recorded;
		byte_t        first_start;
		line_result_t pending_lines[$];
		int           errors;

		function new();
			foreach (pattern[k]) pattern[k] = '0;
			length_reg = '0;
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			foreach (window[k]) window[k] = '0;
			seen = '0;
			hit_recorded = 1'b0;
			first_start = '0;
		endfunction

		function int unsigned used_len();
			return (length_reg > LEN_CLAMP) ? LEN_CLAMP : length_reg;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				REG_FIRST: for (int k = 0; k < 8; k++) pattern[k] = value[8*k +: 8];
				REG_LAST:  for (int k = 0; k < 8; k++) pattern[8+k] = value[8*k +: 8];
				REG_LEN:   length_reg = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// Note one accepted text byte; queue the line result on a line end.
		function void take_byte(byte_t value, bit last);
			int unsigned  len;
			int unsigned  count;
			int unsigned  start;
			bit           hit;
			line_result_t res;
			len = used_len();
			count = seen + 1;
			for (int i = PATTERN_CAP - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = value;
			if (seen < SEEN_CAP) seen++;
			if (len > 0 && count >= len && !hit_recorded) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++)
					if (window[len-1-k] != pattern[k]) hit = 1'b0;
				if (hit) begin
					start = count - len;
					hit_recorded = 1'b1;
					first_start = (start > POS_CAP) ? POS_CAP : byte_t'(start);
				end
			end
			if (last) begin
				res.found = (len == 0) || hit_recorded;
				res.position = (len != 0 && hit_recorded) ? first_start : 8'd0;
				pending_lines.push_back(res);
				clear_line();
			end
		endfunction

		function void report_mismatch(string msg);
			errors++;
			if (errors <= MAX_REPORTS) $display("%s", msg);
		endfunction

		function void check_line_result(logic got_found, logic [7:0] got_position);
			line_result_t want;
			if (pending_lines.size() == 0) begin
				report_mismatch($sformatf("line result with none pending: found=%0d position=%0d",
					got_found, got_position));
				return;
			end
			want = pending_lines.pop_front();
			if (want.found !== got_found || want.position !== got_position)
				report_mismatch($sformatf(
					"line result mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
					want.found, want.position, got_found, got_position));
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        text_byte = '0;
	logic              line_end = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              found;
	logic [POS_W-1:0]  match_position;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	search_scoreboard sb = new();
	byte_t            line_bytes[$];
	int unsigned      send_idle_pct = 0;
	int unsigned      recv_idle_pct = 0;
	int               cycle_count = 0;

	substring_first_match u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.line_end       (line_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.match_position (match_position),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Throttle the result side. Drive at the rising edge only.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample at the falling edge, where everything has settled: valid and
	// ready high here means the result transaction completes at the next
	// rising edge, so check it exactly once.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_line_result(found, match_position);
	end

	// Present one text byte, with random idle cycles ahead of it, and hold it
	// until the transaction completes.
	task automatic send_byte(input byte_t value, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= value;
		line_end  <= last;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.take_byte(value, last);
	endtask

	// Stream line_bytes; flag the last byte only when the line is to end here.
	task automatic send_line(input bit terminate);
		foreach (line_bytes[i])
			send_byte(line_bytes[i], terminate && (i == line_bytes.size() - 1));
	endtask

	// Drop valid, wait for every owed result, then let the compare stage empty
	// of bytes that owe nothing before the registers may change.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_lines.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the data at the edge
	// that ends the access cycle.
	task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Load a fresh pattern and length. Some patterns draw on two byte values
	// only, so that overlapping and partial matches come up often.
	task automatic write_random_config();
		logic [63:0] word;
		int unsigned pick;
		int unsigned len;
		bit          narrow;
		byte_t       a;
		byte_t       b;
		narrow = ($urandom_range(3) == 0);
		a = byte_t'($urandom_range(255));
		b = byte_t'($urandom_range(255));
		for (int r = 0; r < 2; r++) begin
			word = {$urandom, $urandom};
			if (narrow)
				for (int k = 0; k < 8; k++) word[8*k +: 8] = $urandom_range(1) ? a : b;
			apb_write((r == 0) ? REG_FIRST : REG_LAST, word);
		end
		pick = $urandom_range(99);
		if (pick < 6)
			len = 0;
		else if (pick < 14)
			len = $urandom_range(17, 31);
		else if (pick < 24)
			len = 16;
		else
			len = $urandom_range(1, 15);
		word = {$urandom, $urandom};
		word[LEN_W-1:0] = len[LEN_W-1:0];
		apb_write(REG_LEN, word);
	endtask

	// Build a line from pattern bytes and noise, then plant zero to two copies
	// of the pattern; some copies get one byte broken, mostly the last one.
	function automatic void fill_line(input int unsigned n);
		int unsigned len;
		int unsigned at;
		int unsigned copies;
		int unsigned spot;
		len = sb.used_len();
		line_bytes.delete();
		for (int unsigned i = 0; i < n; i++) begin
			if (len != 0 && $urandom_range(1))
				line_bytes.push_back(sb.pattern[$urandom_range(len - 1)]);
			else
				line_bytes.push_back(byte_t'($urandom_range(255)));
		end
		if (len != 0 && n >= len) begin
			copies = $urandom_range(2);
			for (int c = 0; c < copies; c++) begin
				at = $urandom_range(n - len);
				for (int k = 0; k < len; k++) line_bytes[at+k] = sb.pattern[k];
				if ($urandom_range(5) == 0) begin
					spot = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : len - 1;
					line_bytes[at+spot] = line_bytes[at+spot] ^ byte_t'($urandom_range(1, 255));
				end
			end
		end
	endfunction

	initial begin
		int unsigned spent;
		int unsigned n;
		int unsigned nlines;
		int unsigned at;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern straight out of reset: found at position 0.
		line_bytes = '{8'h00};
		send_line(1'b1);

		// Pattern FF 00 of length 2.
		drain_pipeline();
		apb_write(REG_FIRST, 64'h0000_0000_0000_00FF);
		apb_write(REG_LEN, 64'd2);
		// Line shorter than the pattern, then a near miss on the last pattern
		// byte, then a hit at position 1.
		line_bytes = '{8'hFF};
		send_line(1'b1);
		line_bytes = '{8'h01, 8'hFF, 8'h01};
		send_line(1'b1);
		line_bytes = '{8'hFF, 8'hFF, 8'h00};
		send_line(1'b1);

		// Shorten the pattern halfway through a line; the line goes on.
		line_bytes = '{8'hAA};
		send_line(1'b0);
		drain_pipeline();
		apb_write(REG_LEN, 64'd1);
		line_bytes = '{8'hFF};
		send_line(1'b1);

		// Length above the cap clamps to a full 16-byte compare.
		drain_pipeline();
		apb_write(REG_FIRST, 64'h7F80_01FE_00FF_55AA);
		apb_write(REG_LAST, 64'hC33C_F00F_0000_FFFF);
		apb_write(REG_LEN, 64'd31);
		line_bytes.delete();
		for (int k = 0; k < PATTERN_CAP; k++) line_bytes.push_back(sb.pattern[k]);
		send_line(1'b1);

		// Random lines in three throttle phases; the config changes every few
		// lines, and now and then a line runs on across the change.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			spent = 0;
			while (spent < SHORT_BUDGET) begin
				drain_pipeline();
				write_random_config();
				nlines = $urandom_range(2, 6);
				for (int j = 0; j < nlines; j++) begin
					n = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 18);
					fill_line(n);
					send_line(!(j == nlines - 1 && $urandom_range(4) == 0));
					spent += n;
				end
			end
		end

		// One line well past SEEN_CAP bytes: the byte count saturates and the first
		// hit lies beyond position 255.
		drain_pipeline();
		apb_write(REG_FIRST, {$urandom, $urandom});
		apb_write(REG_LEN, 64'd6);
		line_bytes.delete();
		for (int i = 0; i < LONG_LINE; i++) line_bytes.push_back(byte_t'($urandom_range(255)));
		at = $urandom_range(300, LONG_LINE - 6);
		for (int k = 0; k < 6; k++) line_bytes[at+k] = sb.pattern[k];
		send_line(1'b1);

		drain_pipeline();
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
